// ----- design/ll1p_pkg.sv -----
// Shared types, codes and result builder for the LL(1) parse engine.
package ll1p_pkg;

    localparam logic [2:0] OP_RULE_SYM = 3'd0;
    localparam logic [2:0] OP_RULE_LEN = 3'd1;
    localparam logic [2:0] OP_CELL     = 3'd2;
    localparam logic [2:0] OP_BEGIN    = 3'd3;
    localparam logic [2:0] OP_TOKEN    = 3'd4;

    localparam logic [3:0] KIND_EXPANDED    = 4'd0;
    localparam logic [3:0] KIND_MATCHED     = 4'd1;
    localparam logic [3:0] KIND_ACCEPTED    = 4'd2;
    localparam logic [3:0] KIND_NO_RULE     = 4'd3;
    localparam logic [3:0] KIND_MISMATCH    = 4'd4;
    localparam logic [3:0] KIND_TRAILING    = 4'd5;
    localparam logic [3:0] KIND_OVERFLOW    = 4'd6;
    localparam logic [3:0] KIND_LIMIT       = 4'd7;
    localparam logic [3:0] KIND_NOT_RUNNING = 4'd8;

    localparam logic [7:0] SYM_END = 8'h24;
    localparam logic [7:0] SYM_EPS = 8'h40;
    localparam logic [7:0] SYM_A   = 8'h41;
    localparam logic [7:0] SYM_Z   = 8'h5A;

    localparam int TERMINALS = 256;
    localparam int CELL_W    = 6;

    typedef struct packed {
        logic [2:0] opcode;
        logic [4:0] rule_index;
        logic [3:0] position;
        logic [7:0] rule_symbol;
        logic [3:0] rule_length;
        logic [4:0] nonterminal;
        logic [7:0] terminal;
        logic       entry_valid;
        logic [7:0] token;
    } in_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [4:0] applied_rule;
        logic [4:0] expanded_nonterminal;
        logic [7:0] seen_token;
        logic       last;
    } out_t;

    function automatic out_t make_result(logic [3:0] kind, logic [4:0] rule,
                                         logic [4:0] nt, logic [7:0] tok,
                                         logic last);
        out_t r;
        r.kind                 = kind;
        r.applied_rule         = rule;
        r.expanded_nonterminal = nt;
        r.seen_token           = tok;
        r.last                 = last;
        return r;
    endfunction

endpackage

// ----- design/ll1p_table_mem.sv -----
// Parse table memory with a clearing pass after reset.
module ll1p_table_mem #(
    parameter int DEPTH = 6656,
    parameter int AW    = 13
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ll1p_pkg::CELL_W-1:0] wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [ll1p_pkg::CELL_W-1:0] rd_data,
    output logic                        busy
);

    logic [ll1p_pkg::CELL_W-1:0] mem [DEPTH];
    logic [AW-1:0]               clr_reg, clr_next;
    logic                        busy_reg, busy_next;

    always_comb begin
        clr_next  = clr_reg;
        busy_next = busy_reg;
        if (busy_reg) begin
            clr_next = clr_reg + AW'(1);
            if (clr_reg == AW'(DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            busy_reg <= 1'b1;
        end else begin
            clr_reg  <= clr_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign busy = busy_reg;

endmodule

// ----- design/ll1p_rule_mem.sv -----
// Production store: body symbols and body lengths.
module ll1p_rule_mem #(
    parameter int SDEPTH = 288,
    parameter int SAW    = 9,
    parameter int LDEPTH = 32,
    parameter int LAW    = 5
) (
    input  logic           aclk,
    input  logic           sym_we,
    input  logic [SAW-1:0] sym_waddr,
    input  logic [7:0]     sym_wdata,
    input  logic [SAW-1:0] sym_raddr,
    output logic [7:0]     sym_rdata,
    input  logic           len_we,
    input  logic [LAW-1:0] len_waddr,
    input  logic [3:0]     len_wdata,
    input  logic [LAW-1:0] len_raddr,
    output logic [3:0]     len_rdata
);

    logic [7:0] sym_mem [SDEPTH];
    logic [3:0] len_mem [LDEPTH];

    always_ff @(posedge aclk) begin
        if (sym_we) begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        sym_rdata <= sym_mem[sym_raddr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

endmodule

// ----- design/ll1p_stack_mem.sv -----
// Symbol stack memory, one write and one registered read port.
module ll1p_stack_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/ll1_table_driven_parser.sv -----
// Top level: LL(1) parse sequencer over table, rule and stack memories.
//
//  channel | ports                  | carries
//  --------+------------------------+-----------------------------------
//  input   | s_valid s_ready s_data | loads, begin, tokens (in_t)
//  result  | m_valid m_ready m_data | expansion / final results (out_t)
//  config  | cfg_valid cfg_ready    | start_symbol in cfg_data
//
// After reset the parse table, NONTERMINALS*256 cells, is cleared with
// s_ready low. Loads are written from idle; begin pushes the end marker
// and the start symbol. A token reads the stack and checks its top first;
// an expansion adds a table read, a length read and a read per body symbol,
// set by the single read port of each memory. A stalled result register
// holds the sequencer; the next load is still taken while a result waits.
module ll1_table_driven_parser #(
    parameter int MAX_RULES      = 32,
    parameter int RULE_LEN       = 9,
    parameter int STACK_DEPTH    = 256,
    parameter int NONTERMINALS   = 26,
    parameter int MAX_EXPANSIONS = 63
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ll1p_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ll1p_pkg::out_t  m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [4:0]      cfg_data
);

    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int AW     = $clog2(STACK_DEPTH);
    localparam int WPW    = $clog2(STACK_DEPTH + RULE_LEN + 1);
    localparam int TDEPTH = NONTERMINALS * ll1p_pkg::TERMINALS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int RDEPTH = MAX_RULES * RULE_LEN;
    localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int LAW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int EW     = $clog2(MAX_EXPANSIONS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_BEGIN = 4'd1;
    localparam logic [3:0] ST_READ  = 4'd2;
    localparam logic [3:0] ST_TOP   = 4'd3;
    localparam logic [3:0] ST_CELL  = 4'd4;
    localparam logic [3:0] ST_LEN   = 4'd5;
    localparam logic [3:0] ST_SYM   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0]           state_reg, state_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    logic                 running_reg, running_next;
    logic [4:0]           start_reg;
    logic [7:0]           tok_reg, tok_next;
    logic [4:0]           idx_reg, idx_next;
    logic [4:0]           rule_reg, rule_next;
    logic [EW-1:0]        exp_reg, exp_next;
    logic [3:0]           i_reg, i_next;
    logic [WPW-1:0]       wp_reg, wp_next;
    ll1p_pkg::out_t       res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    ll1p_pkg::out_t       m_data_reg, m_data_next;

    logic                        tbl_we, tbl_busy;
    logic [TAW-1:0]              tbl_waddr, tbl_raddr;
    logic [ll1p_pkg::CELL_W-1:0] tbl_wdata, tbl_rdata;
    logic                        sym_we, len_we;
    logic [RAW-1:0]              sym_waddr, sym_raddr;
    logic [7:0]                  sym_wdata, sym_rdata;
    logic [LAW-1:0]              len_waddr, len_raddr;
    logic [3:0]                  len_wdata, len_rdata;
    logic                        stk_we;
    logic [AW-1:0]               stk_waddr, stk_raddr;
    logic [7:0]                  stk_wdata, stk_rdata;

    logic       accept, load;
    logic [7:0] top, nt_idx;
    logic [3:0] blen;

    ll1p_table_mem #(.DEPTH(TDEPTH), .AW(TAW)) u_table (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(tbl_we), .wr_addr(tbl_waddr), .wr_data(tbl_wdata),
        .rd_addr(tbl_raddr), .rd_data(tbl_rdata), .busy(tbl_busy)
    );

    ll1p_rule_mem #(.SDEPTH(RDEPTH), .SAW(RAW), .LDEPTH(MAX_RULES), .LAW(LAW)) u_rules (
        .aclk(aclk),
        .sym_we(sym_we), .sym_waddr(sym_waddr), .sym_wdata(sym_wdata),
        .sym_raddr(sym_raddr), .sym_rdata(sym_rdata),
        .len_we(len_we), .len_waddr(len_waddr), .len_wdata(len_wdata),
        .len_raddr(len_raddr), .len_rdata(len_rdata)
    );

    ll1p_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .aclk(aclk),
        .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
        .rd_addr(stk_raddr), .rd_data(stk_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE) && !tbl_busy;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign top    = (sp_reg == '0 || sp_reg > SPW'(STACK_DEPTH)) ? ll1p_pkg::SYM_END
                                                                 : stk_rdata;
    assign nt_idx = top - ll1p_pkg::SYM_A;
    assign blen   = (int'(len_rdata) > RULE_LEN) ? 4'(RULE_LEN) : len_rdata;

    always_comb begin
        state_next   = state_reg;
        sp_next      = sp_reg;
        running_next = running_reg;
        tok_next     = tok_reg;
        idx_next     = idx_reg;
        rule_next    = rule_reg;
        exp_next     = exp_reg;
        i_next       = i_reg;
        wp_next      = wp_reg;
        res_next     = res_reg;
        load         = 1'b0;

        tbl_we    = 1'b0;
        tbl_waddr = TAW'(int'(s_data.nonterminal) * ll1p_pkg::TERMINALS
                         + int'(s_data.terminal));
        tbl_wdata = s_data.entry_valid ? {1'b1, s_data.rule_index} : '0;
        tbl_raddr = TAW'(int'(nt_idx) * ll1p_pkg::TERMINALS + int'(tok_reg));
        sym_we    = 1'b0;
        sym_waddr = RAW'(int'(s_data.rule_index) * RULE_LEN + int'(s_data.position));
        sym_wdata = s_data.rule_symbol;
        sym_raddr = RAW'(int'(rule_reg) * RULE_LEN + int'(blen) - 1);
        len_we    = 1'b0;
        len_waddr = LAW'(s_data.rule_index);
        len_wdata = (int'(s_data.rule_length) > RULE_LEN) ? 4'(RULE_LEN)
                                                          : s_data.rule_length;
        len_raddr = LAW'(tbl_rdata[4:0]);
        stk_we    = 1'b0;
        stk_waddr = AW'(wp_reg);
        stk_wdata = sym_rdata;
        stk_raddr = AW'(sp_reg - SPW'(1));

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_data.opcode)
                        ll1p_pkg::OP_RULE_SYM: begin
                            sym_we = (int'(s_data.rule_index) < MAX_RULES)
                                  && (int'(s_data.position) < RULE_LEN);
                        end
                        ll1p_pkg::OP_RULE_LEN: begin
                            len_we = int'(s_data.rule_index) < MAX_RULES;
                        end
                        ll1p_pkg::OP_CELL: begin
                            tbl_we = int'(s_data.nonterminal) < NONTERMINALS;
                        end
                        ll1p_pkg::OP_BEGIN: begin
                            stk_we       = 1'b1;
                            stk_waddr    = '0;
                            stk_wdata    = ll1p_pkg::SYM_END;
                            sp_next      = SPW'(2);
                            running_next = 1'b1;
                            state_next   = ST_BEGIN;
                        end
                        ll1p_pkg::OP_TOKEN: begin
                            tok_next = s_data.token;
                            exp_next = '0;
                            if (!running_reg) begin
                                res_next = ll1p_pkg::make_result(
                                    ll1p_pkg::KIND_NOT_RUNNING, '0, '0, s_data.token, 1'b1);
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_BEGIN: begin
                stk_we     = 1'b1;
                stk_waddr  = AW'(1);
                stk_wdata  = ll1p_pkg::SYM_A + {3'b000, start_reg};
                state_next = ST_IDLE;
            end
            ST_READ: begin
                state_next = ST_TOP;
            end
            ST_TOP: begin
                state_next = ST_EMIT;
                if (top == ll1p_pkg::SYM_END) begin
                    res_next = ll1p_pkg::make_result(
                        (tok_reg == ll1p_pkg::SYM_END) ? ll1p_pkg::KIND_ACCEPTED
                                                       : ll1p_pkg::KIND_TRAILING,
                        '0, '0, tok_reg, 1'b1);
                    running_next = 1'b0;
                end else if (top >= ll1p_pkg::SYM_A && top <= ll1p_pkg::SYM_Z) begin
                    idx_next = nt_idx[4:0];
                    if (int'(nt_idx) >= NONTERMINALS) begin
                        res_next = ll1p_pkg::make_result(
                            ll1p_pkg::KIND_NO_RULE, '0, nt_idx[4:0], tok_reg, 1'b1);
                        running_next = 1'b0;
                    end else begin
                        state_next = ST_CELL;
                    end
                end else if (top == tok_reg) begin
                    sp_next  = sp_reg - SPW'(1);
                    res_next = ll1p_pkg::make_result(
                        ll1p_pkg::KIND_MATCHED, '0, '0, tok_reg, 1'b1);
                end else begin
                    res_next = ll1p_pkg::make_result(
                        ll1p_pkg::KIND_MISMATCH, '0, '0, tok_reg, 1'b1);
                    running_next = 1'b0;
                end
            end
            ST_CELL: begin
                state_next = ST_EMIT;
                if (!tbl_rdata[5] || int'(tbl_rdata[4:0]) >= MAX_RULES) begin
                    res_next = ll1p_pkg::make_result(
                        ll1p_pkg::KIND_NO_RULE, '0, idx_reg, tok_reg, 1'b1);
                    running_next = 1'b0;
                end else if (int'(exp_reg) >= MAX_EXPANSIONS) begin
                    res_next = ll1p_pkg::make_result(
                        ll1p_pkg::KIND_LIMIT, '0, idx_reg, tok_reg, 1'b1);
                    running_next = 1'b0;
                end else begin
                    rule_next  = tbl_rdata[4:0];
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                // body is written over the popped nonterminal, right to left
                wp_next = WPW'(sp_reg) - WPW'(1);
                if (blen == '0) begin
                    state_next = ST_FIN;
                end else begin
                    i_next     = blen - 4'd1;
                    state_next = ST_SYM;
                end
            end
            ST_SYM: begin
                sym_raddr = RAW'(int'(rule_reg) * RULE_LEN + int'(i_reg) - 1);
                if (sym_rdata != ll1p_pkg::SYM_EPS) begin
                    // writes past the top are dropped; FIN reports overflow
                    stk_we  = wp_reg < WPW'(STACK_DEPTH);
                    wp_next = wp_reg + WPW'(1);
                end
                if (i_reg == '0) begin
                    state_next = ST_FIN;
                end else begin
                    i_next = i_reg - 4'd1;
                end
            end
            ST_FIN: begin
                state_next = ST_EMIT;
                if (wp_reg > WPW'(STACK_DEPTH)) begin
                    res_next = ll1p_pkg::make_result(
                        ll1p_pkg::KIND_OVERFLOW, rule_reg, idx_reg, tok_reg, 1'b1);
                    running_next = 1'b0;
                end else begin
                    sp_next  = SPW'(wp_reg);
                    exp_next = exp_reg + EW'(1);
                    res_next = ll1p_pkg::make_result(
                        ll1p_pkg::KIND_EXPANDED, rule_reg, idx_reg, tok_reg, 1'b0);
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load       = 1'b1;
                    state_next = res_reg.last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = load || (m_valid_reg && !m_ready);
        m_data_next  = load ? res_reg : m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            sp_reg      <= '0;
            running_reg <= 1'b0;
            start_reg   <= '0;
            exp_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            running_reg <= running_next;
            exp_reg     <= exp_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                start_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg    <= tok_next;
        idx_reg    <= idx_next;
        rule_reg   <= rule_next;
        i_reg      <= i_next;
        wp_reg     <= wp_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_busy |-> !s_ready)
        else $error("input accepted during table clear");

    a_sp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_expansion_keeps_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !res_reg.last) |-> running_reg)
        else $error("expansion result while parse stopped");

    a_exp_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(exp_reg) <= MAX_EXPANSIONS)
        else $error("expansion count past limit");
`endif

endmodule
